// ===== src/kgd_pkg.sv =====
`timescale 1ns / 1ps
package kgd_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TAP_TIME   = 2'd0,
    CFG_MULTI_TIME = 2'd1,
    CFG_LONG_TIME  = 2'd2
  } cfg_idx_t;

  // Controller state: sweep the store after reset, then run
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } ctl_state_t;

  // Per-key flag bit positions
  localparam int FLAG_PRESS   = 0;
  localparam int FLAG_RELEASE = 1;
  localparam int FLAG_HOLD    = 2;
  localparam int FLAG_TAP     = 3;
  localparam int FLAG_MULTI   = 4;
  localparam int FLAG_LONG    = 5;
  localparam int FLAG_FIRED   = 6;
  localparam int FLAG_GAPRUN  = 7;

  localparam logic [15:0] TAP_TIME_RST   = 16'd200;
  localparam logic [15:0] MULTI_TIME_RST = 16'd300;
  localparam logic [15:0] LONG_TIME_RST  = 16'd750;

  localparam logic [15:0] SUM_MAX  = 16'hFFFF;
  localparam logic [7:0]  TAPS_MAX = 8'hFF;

  // Gesture thresholds in milliseconds
  typedef struct packed {
    logic [15:0] long_press_time;
    logic [15:0] multi_tap_time;
    logic [15:0] tap_time;
  } cfg_t;

  // Per-key status fields of fixed width (timers kept apart)
  typedef struct packed {
    logic [7:0]  run_taps;
    logic [15:0] repeat_sum;
    logic [7:0]  last_repeat;
    logic [7:0]  flags;
  } key_stat_t;

endpackage

// ===== src/kgd_update.sv =====
`timescale 1ns / 1ps
module kgd_update #(
  parameter int TIME_BITS = 16
) (
  input  logic [1:0]            kind,
  input  logic [7:0]            repeat_in,
  input  logic [9:0]            elapsed,
  input  kgd_pkg::cfg_t         cfg,
  input  kgd_pkg::key_stat_t    stat_i,
  input  logic [TIME_BITS-1:0]  hold_i,
  input  logic [TIME_BITS-1:0]  gap_i,
  output kgd_pkg::key_stat_t    stat_o,
  output logic [TIME_BITS-1:0]  hold_o,
  output logic [TIME_BITS-1:0]  gap_o
);

  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int SW = ((TIME_BITS > 10) ? TIME_BITS : 10) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [7:0]           f;
  logic [7:0]           last;
  logic [7:0]           taps;
  logic [15:0]          sum;
  logic [16:0]          sum_ext;
  logic [TIME_BITS-1:0] h;
  logic [TIME_BITS-1:0] g;

  // Saturating timer add
  function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] t,
                                                    input logic [9:0] d);
    logic [SW-1:0] s;
    s = SW'(t) + SW'(d);
    if (s > SW'(TMAX)) begin
      time_add = TMAX;
    end else begin
      time_add = s[TIME_BITS-1:0];
    end
  endfunction

  // Apply one press, release or tick to the key entry
  always_comb begin
    f       = stat_i.flags;
    last    = stat_i.last_repeat;
    taps    = stat_i.run_taps;
    sum     = stat_i.repeat_sum;
    h       = hold_i;
    g       = gap_i;
    sum_ext = 17'(stat_i.repeat_sum) + 17'(repeat_in);
    case (kgd_pkg::kind_t'(kind))
      kgd_pkg::KIND_PRESS: begin
        if (!f[kgd_pkg::FLAG_HOLD]) f[kgd_pkg::FLAG_PRESS] = 1'b1;
        f[kgd_pkg::FLAG_RELEASE] = 1'b0;
        f[kgd_pkg::FLAG_HOLD]    = 1'b1;
        last = repeat_in;
        sum  = sum_ext[16] ? kgd_pkg::SUM_MAX : sum_ext[15:0];
        g    = '0;
      end
      kgd_pkg::KIND_RELEASE: begin
        f[kgd_pkg::FLAG_PRESS]   = 1'b0;
        f[kgd_pkg::FLAG_HOLD]    = 1'b0;
        f[kgd_pkg::FLAG_FIRED]   = 1'b0;
        f[kgd_pkg::FLAG_RELEASE] = 1'b1;
        f[kgd_pkg::FLAG_GAPRUN]  = 1'b1;
        last = '0;
        sum  = '0;
        if (CW'(hold_i) < CW'(cfg.tap_time)) f[kgd_pkg::FLAG_TAP] = 1'b1;
        h = '0;
      end
      kgd_pkg::KIND_TICK: begin
        last = '0;
        f[kgd_pkg::FLAG_TAP]   = 1'b0;
        f[kgd_pkg::FLAG_MULTI] = 1'b0;
        f[kgd_pkg::FLAG_LONG]  = 1'b0;
        // advance the gap window, close it once it runs past the limit
        if (f[kgd_pkg::FLAG_GAPRUN]) begin
          g = time_add(g, elapsed);
          if (CW'(g) > CW'(cfg.multi_tap_time)) begin
            g    = '0;
            f[kgd_pkg::FLAG_GAPRUN] = 1'b0;
            taps = '0;
          end
        end
        // new press inside the window counts as a multi-tap
        if (f[kgd_pkg::FLAG_PRESS] && f[kgd_pkg::FLAG_GAPRUN]) begin
          if (CW'(g) < CW'(cfg.multi_tap_time)) begin
            f[kgd_pkg::FLAG_MULTI] = 1'b1;
            if (taps != kgd_pkg::TAPS_MAX) taps = taps + 8'd1;
            g = '0;
          end
          f[kgd_pkg::FLAG_GAPRUN] = 1'b0;
        end
        // advance the hold timer, fire long-press once per hold
        if (f[kgd_pkg::FLAG_HOLD]) begin
          f[kgd_pkg::FLAG_PRESS] = 1'b0;
          h = time_add(h, elapsed);
          if ((CW'(h) > CW'(cfg.long_press_time)) && !f[kgd_pkg::FLAG_FIRED]) begin
            f[kgd_pkg::FLAG_FIRED] = 1'b1;
            f[kgd_pkg::FLAG_LONG]  = 1'b1;
            h = '0;
          end
        end
      end
      default: begin
        // unused kind: leave the entry as it is
      end
    endcase
    stat_o.flags       = f;
    stat_o.last_repeat = last;
    stat_o.repeat_sum  = sum;
    stat_o.run_taps    = taps;
    hold_o = h;
    gap_o  = g;
  end

endmodule

// ===== src/key_gesture_detector_core.sv =====
`timescale 1ns / 1ps
// Channel  Ports                           Direction  Contents
// in       in_tvalid/in_tready/in_t*       input      one press, release or tick item
// out      out_tvalid/out_tready/out_t*    output     key status after the item
// cfg      cfg_valid/cfg_ready/cfg_*       input      threshold register writes
//
// One item per cycle sustained while the output is not stalled; an item's status is read
// from the store at accept, then updated, written back and registered in the output register.
// A back-to-back item for the same key takes the just-written entry by forwarding.
// After reset the store is swept to zero; no item is taken meanwhile, configuration
// writes are. A stalled output stalls the update stage and then the input; cfg_ready
// is always high.
module key_gesture_detector_core #(
  parameter int NUM_KEYS  = 128,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // key_index[6:0], repeat_in[14:7], elapsed[24:15], zero pad
  input  logic [1:0]  in_tuser,  // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // key_out[6:0], pressed[7], released[8], held[9], repeat_now[17:10], tapped[18],
  // multi_tapped[19], long_pressed[20], repeat_total[36:21], tap_count[44:37], zero pad
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int SBITS = $bits(kgd_pkg::key_stat_t);
  localparam int EW = SBITS + 2 * TIME_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_KEYS - 1);

  // configuration
  kgd_pkg::cfg_t cfg_r;

  // control
  kgd_pkg::ctl_state_t state_r, state_nxt;
  logic [AW-1:0] clr_idx_r;
  logic          clearing;

  // input side
  logic          in_acc;
  logic [6:0]    in_key;
  logic          in_inr;
  logic [AW-1:0] in_addr;

  // update stage
  logic          s1_vld_r;
  logic [1:0]    s1_kind_r;
  logic [6:0]    s1_key_r;
  logic [7:0]    s1_rep_r;
  logic [9:0]    s1_dt_r;
  logic          s1_inr_r;
  logic [AW-1:0] s1_addr_r;
  logic          adv;

  // store and forwarding
  logic [EW-1:0] mem [NUM_KEYS];
  logic [EW-1:0] rd_q_r;
  logic          fwd_vld_r;
  logic [AW-1:0] fwd_addr_r;
  logic [EW-1:0] fwd_q_r;
  logic [EW-1:0] cur;
  logic [EW-1:0] upd;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  kgd_pkg::key_stat_t   cur_stat, upd_stat;
  logic [TIME_BITS-1:0] cur_hold, cur_gap, upd_hold, upd_gap;

  // output register
  logic        out_vld_r;
  logic [47:0] out_data_r;
  logic [47:0] out_data_nxt;

  // Configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_time        <= kgd_pkg::TAP_TIME_RST;
      cfg_r.multi_tap_time  <= kgd_pkg::MULTI_TIME_RST;
      cfg_r.long_press_time <= kgd_pkg::LONG_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (kgd_pkg::cfg_idx_t'(cfg_index))
        kgd_pkg::CFG_TAP_TIME:   cfg_r.tap_time        <= cfg_data;
        kgd_pkg::CFG_MULTI_TIME: cfg_r.multi_tap_time  <= cfg_data;
        kgd_pkg::CFG_LONG_TIME:  cfg_r.long_press_time <= cfg_data;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Controller: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kgd_pkg::ST_CLEAR: if (clr_idx_r == LAST_IDX) state_nxt = kgd_pkg::ST_RUN;
      kgd_pkg::ST_RUN:   state_nxt = kgd_pkg::ST_RUN;
      default:           state_nxt = kgd_pkg::ST_CLEAR;
    endcase
  end

  // Controller: outputs
  always_comb begin
    case (state_r)
      kgd_pkg::ST_CLEAR: clearing = 1'b1;
      default:           clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kgd_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // Input decode and handshake
  assign in_key    = in_tdata[6:0];
  assign in_inr    = (32'(in_key) < 32'(NUM_KEYS));
  assign in_addr   = AW'(in_key);
  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clearing && (!s1_vld_r || adv);
  assign in_acc    = in_tvalid && in_tready;

  // Capture the item for the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_key_r  <= in_key;
      s1_rep_r  <= in_tdata[14:7];
      s1_dt_r   <= in_tdata[24:15];
      s1_inr_r  <= in_inr;
      s1_addr_r <= in_addr;
    end
  end

  // Store: one read port at accept, one write port for clear sweep or write-back
  assign mem_we = clearing || (adv && s1_inr_r);
  assign mem_wa = clearing ? clr_idx_r : s1_addr_r;
  assign mem_wd = clearing ? '0 : upd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_acc && in_inr) rd_q_r <= mem[in_addr];
  end

  // Hold the last written entry to cover a read that raced its write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (adv && s1_inr_r) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_inr_r) begin
      fwd_addr_r <= s1_addr_r;
      fwd_q_r    <= upd;
    end
  end

  assign cur = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_q_r : rd_q_r;
  assign cur_stat = kgd_pkg::key_stat_t'(cur[SBITS-1:0]);
  assign cur_hold = cur[SBITS +: TIME_BITS];
  assign cur_gap  = cur[SBITS + TIME_BITS +: TIME_BITS];

  kgd_update #(
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .kind      (s1_kind_r),
    .repeat_in (s1_rep_r),
    .elapsed   (s1_dt_r),
    .cfg       (cfg_r),
    .stat_i    (cur_stat),
    .hold_i    (cur_hold),
    .gap_i     (cur_gap),
    .stat_o    (upd_stat),
    .hold_o    (upd_hold),
    .gap_o     (upd_gap)
  );

  assign upd = {upd_gap, upd_hold, upd_stat};

  // Pack the status item; an out-of-range key reports its index with zero status
  always_comb begin
    if (s1_inr_r) begin
      out_data_nxt = {3'b000,
                      upd_stat.run_taps,
                      upd_stat.repeat_sum,
                      upd_stat.flags[kgd_pkg::FLAG_LONG],
                      upd_stat.flags[kgd_pkg::FLAG_MULTI],
                      upd_stat.flags[kgd_pkg::FLAG_TAP],
                      upd_stat.last_repeat,
                      upd_stat.flags[kgd_pkg::FLAG_HOLD],
                      upd_stat.flags[kgd_pkg::FLAG_RELEASE],
                      upd_stat.flags[kgd_pkg::FLAG_PRESS],
                      s1_key_r};
    end else begin
      out_data_nxt = {41'd0, s1_key_r};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // No item enters while the store is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_acc)
    else $error("item accepted during clear sweep");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !adv)
    else $error("pending output overwritten");

  // An out-of-range key never touches the store after the sweep
  a_oor_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_inr_r && !clearing) |-> !mem_we)
    else $error("store written for out-of-range key");

  // Each write-back leaves a result behind it in the output register
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("write-back without result");

endmodule
